### src/assert_macros.svh
// Assertion macros shared by the JSON string unescape RTL.
// Needs nothing else; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// An implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// A condition that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### src/jsu_pkg.sv
// Package for the JSON string unescape block: types, codes and the
// hex digit and UTF-8 helper functions. Depends on nothing.
package jsu_pkg;

  localparam int CAP_W            = 13;
  localparam int LEN_W            = 12;
  localparam int ADDR_W           = 3;
  localparam int DATA_W           = 32;
  localparam int MAX_CAPACITY_DEF = 4096;
  localparam int QDEPTH           = 4;

  localparam logic [CAP_W-1:0]  CAP_RESET     = 13'd64;
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;

  localparam logic OP_CONTENT  = 1'b0;
  localparam logic OP_END      = 1'b1;
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_TAB       = 8'h09;

  localparam logic [15:0] CP_MAX1   = 16'h007f;
  localparam logic [15:0] CP_MAX2   = 16'h07ff;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_BAD_ESCAPE = 2'd2
  } status_t;

  // One queued request result: either one to three decoded bytes or a status.
  typedef struct packed {
    logic             kind;
    logic [1:0]       nbytes;
    logic [2:0][7:0]  bytes;
    logic [1:0]       status;
    logic [LEN_W-1:0] length;
  } group_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] b;
  } utf8_t;

  function automatic hex_t hex_nibble(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h37);
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t u;
    u = '0;
    if (cp <= CP_MAX1) begin
      u.n    = 2'd1;
      u.b[0] = cp[7:0];
    end else if (cp <= CP_MAX2) begin
      u.n    = 2'd2;
      u.b[0] = UTF8_LEAD2 | {3'b0, cp[10:6]};
      u.b[1] = UTF8_CONT | {2'b0, cp[5:0]};
    end else begin
      u.n    = 2'd3;
      u.b[0] = UTF8_LEAD3 | {4'b0, cp[15:12]};
      u.b[1] = UTF8_CONT | {2'b0, cp[11:6]};
      u.b[2] = UTF8_CONT | {2'b0, cp[5:0]};
    end
    return u;
  endfunction

endpackage

### src/jsu_result_queue.sv
// Result queue of the JSON string unescape block: holds whole result groups and
// hands them out one result per result_ready cycle. Depends on jsu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jsu_result_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsu_pkg::group_t push_grp,
  output logic            has_room,
  output logic            result_valid,
  input  logic            result_ready,
  output logic            kind,
  output logic [7:0]      out_byte,
  output logic [1:0]      status,
  output logic [11:0]     out_length,
  output logic            last
);
  import jsu_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  group_t           mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [1:0]       sub;
  group_t           head;
  logic             pop_res;
  logic             pop_grp;

  assign head         = mem[rd_ptr];
  assign result_valid = (count != '0);
  assign has_room     = (count != CNT_W'(QDEPTH));
  assign pop_res      = result_valid && result_ready;
  assign last         = (sub == head.nbytes - 2'd1);
  assign pop_grp      = pop_res && last;

  assign kind       = head.kind;
  assign out_byte   = head.bytes[sub];
  assign status     = head.status;
  assign out_length = head.length;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_grp) begin
        rd_ptr <= rd_ptr + 1'b1;
        sub    <= '0;
      end else if (pop_res) begin
        sub <= sub + 2'd1;
      end
      if (push && !pop_grp) begin
        count <= count + 1'b1;
      end else if (!push && pop_grp) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(QDEPTH), "queue count beyond depth")
  `ASSERT_IMPLY(a_push_room, clk, rst, push, has_room, "push into a full queue")
  `ASSERT_IMPLY(a_sub_in_group, clk, rst, result_valid, sub < head.nbytes, "byte index past group")
  `ASSERT_IMPLY(a_sub_idle, clk, rst, count == '0, sub == 2'd0, "byte index set on empty queue")

endmodule

### src/json_string_unescape.sv
// Top level of the JSON string unescape block: APB register, escape decoder
// and capacity check. Depends on jsu_pkg, jsu_result_queue and assert_macros.svh.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  item     | item_valid / item_ready    | op, data_byte
//  result   | result_valid / result_ready| kind, out_byte, status, out_length, last
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// An item is decoded in the cycle it is accepted; its results are registered in
// the result queue and leave at one per cycle while result_ready is high, so an
// item with a three-byte code point gives three results on the result port.
// The result queue holds four result groups; item_ready drops only when it is full.
// Reset is synchronous; it clears the decoder state and the queue and sets the capacity register to 64.
`include "assert_macros.svh"

module json_string_unescape #(
  parameter int MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic                      op,
  input  logic [7:0]                data_byte,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic                      kind,
  output logic [7:0]                out_byte,
  output logic [1:0]                status,
  output logic [11:0]               out_length,
  output logic                      last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [jsu_pkg::ADDR_W-1:0] paddr,
  input  logic [jsu_pkg::DATA_W-1:0] pwdata,
  output logic [jsu_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import jsu_pkg::*;

  localparam int CNT_W = $clog2(MAX_CAPACITY);
  localparam int CMP_W = ((CNT_W + 1 > CAP_W) ? CNT_W + 1 : CAP_W) + 1;

  logic [CAP_W-1:0] capacity;
  mode_t            mode, mode_next;
  logic [1:0]       hex_seen, hex_seen_next;
  logic [15:0]      code_point, code_point_next;
  logic [CNT_W-1:0] written, written_next;
  status_t          err, err_next;

  logic             accept;
  logic             push;
  logic             has_room;
  group_t           grp;
  logic [CMP_W-1:0] eff_cap;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] wr_ext;
  logic [CMP_W-1:0] sum;
  logic             app_req;
  logic [1:0]       app_n;
  logic [2:0][7:0]  app_b;
  hex_t             hex;
  utf8_t            utf;
  logic [15:0]      cp_shift;
  status_t          end_status;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign item_ready = has_room;
  assign accept     = item_valid && item_ready;

  assign cap_ext  = CMP_W'(capacity);
  assign eff_cap  = (cap_ext > CMP_W'(MAX_CAPACITY)) ? CMP_W'(MAX_CAPACITY) : cap_ext;
  assign wr_ext   = CMP_W'(written);
  assign sum      = wr_ext + CMP_W'(app_n);
  assign hex      = hex_nibble(data_byte);
  assign cp_shift = {code_point[11:0], hex.value};
  assign utf      = utf8_encode(cp_shift);

  always_comb begin
    if (err != ST_OK) begin
      end_status = err;
    end else if (mode == MODE_ESCAPE || mode == MODE_HEX) begin
      end_status = ST_BAD_ESCAPE;
    end else if (eff_cap == '0) begin
      end_status = ST_OVERFLOW;
    end else begin
      end_status = ST_OK;
    end
  end

  always_comb begin
    mode_next       = mode;
    hex_seen_next   = hex_seen;
    code_point_next = code_point;
    written_next    = written;
    err_next        = err;
    push            = 1'b0;
    grp             = '0;
    app_req         = 1'b0;
    app_n           = 2'd1;
    app_b           = '0;

    if (accept) begin
      if (op == OP_END) begin
        push            = 1'b1;
        grp.kind        = KIND_STATUS;
        grp.nbytes      = 2'd1;
        grp.status      = end_status;
        grp.length      = (end_status == ST_OK) ? wr_ext[LEN_W-1:0] : '0;
        mode_next       = MODE_NORMAL;
        hex_seen_next   = '0;
        code_point_next = '0;
        written_next    = '0;
        err_next        = ST_OK;
      end else if (err == ST_OK) begin
        unique case (mode)
          MODE_ESCAPE: begin
            if (data_byte == CH_U) begin
              mode_next       = MODE_HEX;
              hex_seen_next   = '0;
              code_point_next = '0;
            end else begin
              mode_next = MODE_NORMAL;
              app_req   = 1'b1;
              case (data_byte)
                CH_N:    app_b[0] = CH_LF;
                CH_R:    app_b[0] = CH_CR;
                CH_T:    app_b[0] = CH_TAB;
                default: app_b[0] = data_byte;
              endcase
            end
          end
          MODE_HEX: begin
            if (!hex.ok) begin
              err_next      = ST_BAD_ESCAPE;
              mode_next     = MODE_NORMAL;
              hex_seen_next = '0;
            end else begin
              code_point_next = cp_shift;
              if (hex_seen == 2'd3) begin
                mode_next     = MODE_NORMAL;
                hex_seen_next = '0;
                app_req       = 1'b1;
                app_n         = utf.n;
                app_b         = utf.b;
              end else begin
                hex_seen_next = hex_seen + 2'd1;
              end
            end
          end
          default: begin
            // The unused mode code decodes like the normal mode.
            mode_next = MODE_NORMAL;
            if (data_byte == CH_BACKSLASH) begin
              mode_next = MODE_ESCAPE;
            end else begin
              app_req  = 1'b1;
              app_b[0] = data_byte;
            end
          end
        endcase

        // A code point is written whole or not at all.
        if (app_req) begin
          if (sum >= eff_cap) begin
            err_next = ST_OVERFLOW;
          end else begin
            push         = 1'b1;
            grp.kind     = KIND_BYTE;
            grp.nbytes   = app_n;
            grp.bytes    = app_b;
            written_next = sum[CNT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      hex_seen   <= '0;
      code_point <= '0;
      written    <= '0;
      err        <= ST_OK;
    end else begin
      mode       <= mode_next;
      hex_seen   <= hex_seen_next;
      code_point <= code_point_next;
      written    <= written_next;
      err        <= err_next;
    end
  end

  jsu_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_grp     (grp),
    .has_room     (has_room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .out_byte     (out_byte),
    .status       (status),
    .out_length   (out_length),
    .last         (last)
  );

  `ASSERT_IMPLY(a_hex_only_in_hex, clk, rst, hex_seen != 2'd0,
                mode == MODE_HEX, "digit count outside hex escape")
  `ASSERT_IMPLY(a_err_mode_normal, clk, rst, err != ST_OK,
                mode == MODE_NORMAL, "error latched inside an escape")
  `ASSERT_NEXT(a_err_sticky, clk, rst, err != ST_OK && !(accept && op == OP_END),
               err == $past(err), "latched error changed")
  `ASSERT_NEXT(a_end_clears, clk, rst, accept && op == OP_END,
               written == '0 && err == ST_OK, "end request left state")

endmodule
